// ----- rtl/srrd_pkg.sv -----
// -----------------------------------------------------------------------------
// srrd_pkg
// Shared types and constants for the sentinel receive ring drain block.
// -----------------------------------------------------------------------------
`default_nettype none

package srrd_pkg;

   // request kinds carried in req_tuser
   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_SCAN  = 2'd1,
      REQ_DRAIN = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   localparam int unsigned ENTRY_W  = 16;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SLOT_W   = 6;
   localparam int unsigned REQ_DATA_W = 24;   // slot + entry, padded to bytes

   // high byte of an entry equal to this marks the entry as empty
   localparam logic [BYTE_W-1:0]  EMPTY_MARK  = 8'hFF;
   localparam logic [ENTRY_W-1:0] EMPTY_ENTRY = 16'hFFFF;

endpackage

`default_nettype wire

// ----- rtl/sentinel_ring_receive_drain_core.sv -----
// -----------------------------------------------------------------------------
// sentinel_ring_receive_drain_core
// Receive ring with an empty marker: slot writes, tail scan, burst drain.
// -----------------------------------------------------------------------------
//
//  Channel | Dir | Signals                          | Carries
//  --------+-----+----------------------------------+-------------------------------
//  req     | in  | tvalid tready tdata[23:0] tuser  | slot, entry value; kind in tuser
//  rsp     | out | tvalid tready tdata[7:0] tlast   | drained byte, last of drain run
//
//  Steps: a write is done in the accept cycle. A scan, after the accept cycle,
//  reads each entry it looks at through the memory read port, then checks it;
//  it looks at no more than DEPTH-1 entries. A drain reads each emitted byte,
//  then loads it into the output register; an empty drain ends on acceptance.
//  Reset: synchronous; the per-entry valid flags clear in the reset cycle, an
//  entry that is not valid reads as all ones, so no clearing pass is needed.
//  Stalls: a drain waits in place while the output register is held by
//  rsp_tready low. One request is in work at a time; req_tready is high only
//  while no request is in work.
//
`default_nettype none

module sentinel_ring_receive_drain_core #(
   parameter int unsigned DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // [5:0] slot, [21:6] entry_value, [23:22] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] req_type

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // [7:0] data_byte
   output      logic        rsp_tlast    // last_byte
);

   localparam int unsigned IDX_W  = $clog2(DEPTH);
   localparam int unsigned STEP_W = $clog2(DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE       = 5'b00001,
      ST_SCAN_RD    = 5'b00010,
      ST_SCAN_CHK   = 5'b00100,
      ST_DRAIN_RD   = 5'b01000,
      ST_DRAIN_EMIT = 5'b10000
   } state_type;

   // ---------------------------------------------------------------- fields
   logic [srrd_pkg::SLOT_W-1:0]  req_slot;
   logic [srrd_pkg::ENTRY_W-1:0] req_entry;
   srrd_pkg::req_kind_type       req_kind;

   assign req_slot  = req_tdata[5:0];
   assign req_entry = req_tdata[21:6];
   assign req_kind  = srrd_pkg::req_kind_type'(req_tuser);

   // ---------------------------------------------------------------- state
   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     read_idx_ff, read_idx_in;   // ring head, walks during drain
   logic [IDX_W-1:0]     fill_idx_ff, fill_idx_in;   // ring tail
   logic [STEP_W-1:0]    steps_ff, steps_in;
   logic [DEPTH-1:0]     valid_ff, valid_in;

   // entry memory, one port each way, registered read
   logic [srrd_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [srrd_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                         rd_vld_ff;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;

   // output register
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [srrd_pkg::BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                 req_fire;
   logic                 out_free;
   logic                 out_load;
   logic                 entry_filled;
   logic [IDX_W-1:0]     fill_next;
   logic [IDX_W-1:0]     read_next;
   logic                 drain_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // ring increment with wrap at DEPTH-1 (DEPTH need not be a power of two)
   assign fill_next = (fill_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(fill_idx_ff + 1'b1);
   assign read_next = (read_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(read_idx_ff + 1'b1);

   // entry from memory, invalid slots read as empty
   assign entry_filled = rd_vld_ff
                         && (rd_data_ff[15:8] != srrd_pkg::EMPTY_MARK);
   assign drain_last   = (read_next == fill_idx_ff);

   assign wr_en   = req_fire && (req_kind == srrd_pkg::REQ_WRITE)
                    && (32'(req_slot) < DEPTH);
   assign wr_addr = IDX_W'(req_slot);

   assign rd_en   = (state_ff == ST_SCAN_RD) || (state_ff == ST_DRAIN_RD);
   assign rd_addr = (state_ff == ST_SCAN_RD) ? fill_idx_ff : read_idx_ff;

   assign out_load = (state_ff == ST_DRAIN_EMIT) && out_free;

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in    = state_ff;
      read_idx_in = read_idx_ff;
      fill_idx_in = fill_idx_ff;
      steps_in    = steps_ff;
      valid_in    = valid_ff;

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_kind)
                  srrd_pkg::REQ_SCAN: begin
                     steps_in = '0;
                     state_in = ST_SCAN_RD;
                  end
                  srrd_pkg::REQ_DRAIN: begin
                     // nothing pending when head meets tail
                     if (read_idx_ff != fill_idx_ff) begin
                        state_in = ST_DRAIN_RD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (entry_filled) begin
               fill_idx_in = fill_next;
               steps_in    = STEP_W'(steps_ff + 1'b1);
               // stop after DEPTH-1 steps
               state_in    = (steps_ff == STEP_W'(DEPTH - 2)) ? ST_IDLE : ST_SCAN_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN_RD: begin
            state_in = ST_DRAIN_EMIT;
         end
         ST_DRAIN_EMIT: begin
            if (out_free) begin
               valid_in[read_idx_ff] = 1'b0;   // drained entry back to empty
               read_idx_in           = read_next;
               state_in              = drain_last ? ST_IDLE : ST_DRAIN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = rd_vld_ff ? rd_data_ff[7:0] : srrd_pkg::EMPTY_ENTRY[7:0];
         rsp_last_in   = drain_last;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         read_idx_ff   <= '0;
         fill_idx_ff   <= '0;
         steps_ff      <= '0;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         read_idx_ff   <= read_idx_in;
         fill_idx_ff   <= fill_idx_in;
         steps_ff      <= steps_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
   end

   // ---------------------------------------------------------------- checks
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN_EMIT) && out_free |=> rsp_tvalid)
      else $error("drain byte not loaded into output register");

   a_drain_ends_at_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN_EMIT) && out_free && drain_last
      |=> (read_idx_ff == fill_idx_ff) && (state_ff == ST_IDLE))
      else $error("drain did not finish with head at tail");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_CHK) |-> (32'(steps_ff) <= DEPTH - 2))
      else $error("scan ran past its step limit");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN_RD) || (state_ff == ST_SCAN_RD) |-> !req_fire)
      else $error("request taken while another is in work");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sentinel receive ring drain core.
// Directed table, then random write/scan/drain episodes against a ring
// predictor, with bursty requests and a stalling result sink.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SLOT_W      = srrd_pkg::SLOT_W;
   localparam int unsigned ENTRY_W     = srrd_pkg::ENTRY_W;
   localparam int unsigned BYTE_W      = srrd_pkg::BYTE_W;
   localparam logic [BYTE_W-1:0]  EMPTY_MARK  = srrd_pkg::EMPTY_MARK;
   localparam logic [ENTRY_W-1:0] EMPTY_ENTRY = srrd_pkg::EMPTY_ENTRY;

   localparam int unsigned RING_DEPTH   = 64;
   localparam int unsigned RANDOM_ITEMS = 340;
   localparam int unsigned LONG_HOLD    = 300;   // long receiver hold-off, cycles
   localparam int unsigned IDLE_LIMIT   = 4000;  // cycles with no handshake at all
   localparam int unsigned N_DIRECTED   = 23;
   localparam logic [7:0]  SINK_PATTERN = 8'b1011_0010;

   // one request as the sender sees it; typed rows carry their own expectation
   typedef struct {
      srrd_pkg::req_kind_type kind;
      logic [SLOT_W-1:0]   slot;
      logic [ENTRY_W-1:0]  value;
      bit                  typed;
      int unsigned         due_count;   // 0 or 1 for typed rows
      logic [BYTE_W-1:0]   due_byte;
      logic                due_last;
   } ring_request_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } drained_byte_type;

   // ---------------------------------------------------------------- clock/reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   // ---------------------------------------------------------------- dut ports
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata  = '0;   // [5:0] slot, [21:6] entry_value, [23:22] zero
   logic [1:0]          req_tuser  = srrd_pkg::REQ_NONE;   // [1:0] req_type
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;   // [7:0] data_byte
   logic                rsp_tlast;   // last_byte

   sentinel_ring_receive_drain_core #(.DEPTH(RING_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------- ring predictor
   // Mirror of the ring: entries, head (oldest undrained) and tail (first unscanned).
   logic [ENTRY_W-1:0] ring_entries [RING_DEPTH];
   logic [SLOT_W-1:0]  head_idx = '0;
   logic [SLOT_W-1:0]  tail_idx = '0;
   drained_byte_type   drain_run [$];   // bytes produced by the latest request
   drained_byte_type   bytes_due [$];   // bytes still to come from the dut

   initial begin
      foreach (ring_entries[i]) ring_entries[i] = EMPTY_ENTRY;
   end

   function automatic logic [SLOT_W-1:0] ring_succ(input logic [SLOT_W-1:0] idx);
      return (idx == SLOT_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   // Applies one accepted request to the mirror; drained bytes land in drain_run.
   function automatic void predict_ring_request(input srrd_pkg::req_kind_type kind,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic [ENTRY_W-1:0] value);
      int unsigned       steps;
      logic [SLOT_W-1:0] idx;
      logic [SLOT_W-1:0] nxt;
      drain_run.delete();
      case (kind)
         srrd_pkg::REQ_WRITE: begin
            ring_entries[slot] = value;
         end
         srrd_pkg::REQ_SCAN: begin
            // walk filled entries, never more than DEPTH-1 of them
            steps = 0;
            while (ring_entries[tail_idx][ENTRY_W-1:BYTE_W] != EMPTY_MARK) begin
               steps++;
               tail_idx = ring_succ(tail_idx);
               if (steps >= RING_DEPTH - 1) break;
            end
         end
         srrd_pkg::REQ_DRAIN: begin
            // the marker is not checked here: a re-emptied entry still drains
            idx = head_idx;
            while (idx != tail_idx) begin
               nxt = ring_succ(idx);
               drain_run.push_back('{ring_entries[idx][BYTE_W-1:0], nxt == tail_idx});
               ring_entries[idx] = EMPTY_ENTRY;
               idx = nxt;
            end
            head_idx = tail_idx;
         end
         default: ;   // unused code: no effect
      endcase
   endfunction

   // ---------------------------------------------------------------- directed table
   // Expectations typed in only where obvious; zero-count rows produce nothing.
   ring_request_type directed_rows [N_DIRECTED] = '{
      // nothing pending right after reset
      '{srrd_pkg::REQ_DRAIN, 6'd0,  16'h0000, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_SCAN,  6'd0,  16'h0000, 1'b1, 0, 8'h00, 1'b0},
      // unused request code must not write the slot
      '{srrd_pkg::REQ_NONE,  6'd1,  16'h1234, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_SCAN,  6'd0,  16'h0000, 1'b1, 0, 8'h00, 1'b0},
      // single entry, single byte with last set
      '{srrd_pkg::REQ_WRITE, 6'd0,  16'h0012, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_SCAN,  6'd0,  16'h0000, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_DRAIN, 6'd0,  16'h0000, 1'b1, 1, 8'h12, 1'b1},
      '{srrd_pkg::REQ_DRAIN, 6'd0,  16'h0000, 1'b1, 0, 8'h00, 1'b0},
      // marker extremes: FE counts as filled, FF as empty; top slot
      '{srrd_pkg::REQ_WRITE, 6'd1,  16'hFEFF, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_WRITE, 6'd2,  16'h0000, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_WRITE, 6'd3,  16'hFF00, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_WRITE, 6'd63, 16'h8001, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_SCAN,  6'd0,  16'h0000, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_DRAIN, 6'd0,  16'h0000, 1'b0, 0, 8'h00, 1'b0},
      // entry set back to empty after the scan still drains
      '{srrd_pkg::REQ_WRITE, 6'd3,  16'h7F5A, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_WRITE, 6'd4,  16'h0155, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_SCAN,  6'd0,  16'h0000, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_WRITE, 6'd4,  16'hFFC3, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_DRAIN, 6'd0,  16'h0000, 1'b0, 0, 8'h00, 1'b0},
      // tail parked on an empty entry: scan and drain do nothing
      '{srrd_pkg::REQ_WRITE, 6'd5,  16'hFFFF, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_SCAN,  6'd0,  16'h0000, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_DRAIN, 6'd0,  16'h0000, 1'b1, 0, 8'h00, 1'b0},
      '{srrd_pkg::REQ_NONE,  6'd63, 16'hFFFF, 1'b1, 0, 8'h00, 1'b0}
   };

   // ---------------------------------------------------------------- tallies
   int unsigned n_writes = 0, n_scans = 0, n_drains = 0, n_ignored = 0;
   int unsigned n_empty_drains = 0, longest_run = 0, bytes_seen = 0;
   int unsigned mismatches = 0;
   int unsigned burst_left = 0;
   logic        hold_rsp = 1'b0;   // asks the sink for one long hold-off

   function automatic ring_request_type plain_request(input srrd_pkg::req_kind_type kind,
                                                      input logic [SLOT_W-1:0] slot,
                                                      input logic [ENTRY_W-1:0] value);
      return '{kind, slot, value, 1'b0, 0, '0, 1'b0};
   endfunction

   // any kind, any slot; a quarter of the values carry the empty marker
   function automatic ring_request_type noise_request();
      logic [BYTE_W-1:0] hi;
      hi = ($urandom_range(0, 3) == 0) ? EMPTY_MARK : BYTE_W'($urandom_range(0, 255));
      return plain_request(srrd_pkg::req_kind_type'($urandom_range(0, 3)),
                           SLOT_W'($urandom_range(0, RING_DEPTH - 1)),
                           {hi, BYTE_W'($urandom_range(0, 255))});
   endfunction

   // Offers one request, waits for the handshake, books the expected bytes,
   // then applies the burst/gap idling of the sender.
   task automatic send_request(input ring_request_type rq);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, rq.value, rq.slot};
      req_tuser  <= rq.kind;
      do @(posedge clock); while (req_tready !== 1'b1);

      predict_ring_request(rq.kind, rq.slot, rq.value);
      if (rq.typed) begin
         if (rq.due_count != 0) bytes_due.push_back('{rq.due_byte, rq.due_last});
      end else begin
         foreach (drain_run[i]) bytes_due.push_back(drain_run[i]);
      end

      case (rq.kind)
         srrd_pkg::REQ_WRITE: n_writes++;
         srrd_pkg::REQ_SCAN:  n_scans++;
         srrd_pkg::REQ_DRAIN: begin
            n_drains++;
            if (drain_run.size() == 0) n_empty_drains++;
            if (drain_run.size() > longest_run) longest_run = drain_run.size();
         end
         default:   n_ignored++;
      endcase

      // bursts of random length; a quarter of them run straight into the next
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // stop offering, then wait for every booked byte
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- result sink
   // Ready pattern steps through four phases in turn: open, mostly ready, fixed
   // rotating mask, mostly stalled. One long hold-off on request.
   initial begin : rsp_sink
      int unsigned tick;
      logic        go;
      bit          hold_taken;
      tick       = 0;
      hold_taken = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            tick++;
            case ((tick / 150) % 4)
               0:       go = 1'b1;
               1:       go = ($urandom_range(0, 3) != 0);
               2:       go = SINK_PATTERN[tick % 8];
               default: go = ($urandom_range(0, 3) == 0);
            endcase
            rsp_tready <= go;
         end
      end
   end

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin : rsp_check
      drained_byte_type due;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         bytes_seen++;
         if (bytes_due.size() == 0) begin
            $error("unexpected byte: data_byte actual %02h, last_byte actual %0b",
                   rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            due = bytes_due.pop_front();
            if (rsp_tdata !== due.data) begin
               $error("data_byte expected %02h actual %02h", due.data, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== due.last) begin
               $error("last_byte expected %0b actual %0b", due.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   // Counts cycles without any handshake; covers the long hold and full scans.
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin : stimulus
      int unsigned       base, run_len, pending, episode;
      logic [SLOT_W-1:0] start;
      bit                full_ring, paused_mid, hold_done;
      paused_mid = 1'b0;
      hold_done  = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) send_request(directed_rows[r]);

      // sender pause: let every pending byte come out
      wait_results_drained();

      // Random episodes. Most are well-formed: a run of filled entries written
      // from the tail on, then a scan, then usually a drain. The rest is noise.
      base    = n_writes + n_scans + n_drains;
      episode = 0;
      while (n_writes + n_scans + n_drains < base + RANDOM_ITEMS) begin
         if (episode == 0 || $urandom_range(0, 3) != 0) begin
            full_ring = (episode == 0) || ($urandom_range(0, 40) == 0);
            if (full_ring)
               run_len = RING_DEPTH;
            else if ($urandom_range(0, 9) == 0)
               run_len = $urandom_range(20, RING_DEPTH - 1);
            else
               run_len = $urandom_range(1, 8);
            start = tail_idx;
            for (int k = 0; k < run_len; k++) begin
               send_request(plain_request(srrd_pkg::REQ_WRITE,
                  SLOT_W'((start + k) % RING_DEPTH),
                  {BYTE_W'($urandom_range(0, 254)), BYTE_W'($urandom_range(0, 255))}));
               if ($urandom_range(0, 11) == 0) send_request(noise_request());
            end
            send_request(plain_request(srrd_pkg::REQ_SCAN, SLOT_W'($urandom_range(0, 63)),
                                       ENTRY_W'($urandom_range(0, 65535))));
            // now and then re-empty an entry inside the pending run
            pending = (tail_idx + RING_DEPTH - head_idx) % RING_DEPTH;
            if (pending != 0 && $urandom_range(0, 5) == 0)
               send_request(plain_request(srrd_pkg::REQ_WRITE,
                  SLOT_W'((head_idx + $urandom_range(0, pending - 1)) % RING_DEPTH),
                  {EMPTY_MARK, BYTE_W'($urandom_range(0, 255))}));
            if (full_ring || $urandom_range(0, 7) != 0) begin
               // first full drain meets a long sink stall; later requests back up
               if (full_ring && !hold_done) begin
                  hold_rsp  <= 1'b1;
                  hold_done  = 1'b1;
               end
               send_request(plain_request(srrd_pkg::REQ_DRAIN, SLOT_W'($urandom_range(0, 63)),
                                          ENTRY_W'($urandom_range(0, 65535))));
            end
         end else begin
            repeat ($urandom_range(1, 6)) send_request(noise_request());
         end
         if (!paused_mid && n_writes + n_scans + n_drains >= base + RANDOM_ITEMS / 2) begin
            wait_results_drained();
            paused_mid = 1'b1;
         end
         episode++;
      end

      wait_results_drained();
      // a scan can still be walking the ring; give stray bytes time to show
      repeat (2 * RING_DEPTH + 8) @(posedge clock);

      if (bytes_due.size() != 0) begin
         $error("%0d expected bytes never arrived", bytes_due.size());
         mismatches++;
      end

      $display("Covered %0d writes, %0d scans, %0d drains (%0d with nothing pending)",
               n_writes, n_scans, n_drains, n_empty_drains);
      $display("%0d unused codes, %0d drained bytes checked, longest run %0d, %0d-cycle hold",
               n_ignored, bytes_seen, longest_run, LONG_HOLD);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/srrd_pkg.sv
rtl/sentinel_ring_receive_drain_core.sv
tb/sv/tb.sv
